>>> rtl/swmv_pkg.sv
// Shared constants, width functions and status types for the sliding-window statistics block.
`timescale 1ns / 1ps

package swmv_pkg;

    localparam int DEFAULT_MAX_WINDOW = 64;

    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 24;
    localparam int VAR_W     = 39;
    localparam int HELD_W    = 7;
    localparam int LEN_W     = 7;
    localparam int LEN_RESET = 64;
    localparam int LEN_MIN   = 2;
    localparam int FRAC_W    = 8;

    localparam int QUEUE_DEPTH        = 2;
    localparam int DIV_BITS_PER_CYCLE = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Ring index width.
    function int idx_w(input int p);
        return $clog2(p);
    endfunction

    // Sample count width, able to hold the window length itself.
    function int cnt_w(input int p);
        return $clog2(p + 1);
    endfunction

    // Signed running sum width.
    function int sum_w(input int p);
        return SAMPLE_W + $clog2(p);
    endfunction

    // Unsigned sum of squares width.
    function int sq_w(input int p);
        return 2 * SAMPLE_W - 1 + $clog2(p);
    endfunction

    // Width of n*sumsq and of sum^2, whichever is wider.
    function int num_w(input int p);
        int pa;
        int pb;
        pa = cnt_w(p) + sq_w(p);
        pb = 2 * sum_w(p);
        return (pa > pb) ? pa : pb;
    endfunction

    function int dvd_w(input int p);
        return num_w(p) + FRAC_W;
    endfunction

    function int den_w(input int p);
        return 2 * cnt_w(p);
    endfunction

    function int job_w(input int p);
        return sum_w(p) + sq_w(p) + cnt_w(p);
    endfunction

endpackage

>>> rtl/swmv_front.sv
// Front end: takes samples, keeps the ring and the running sums, and queues one job per sample.
`timescale 1ns / 1ps

module swmv_front #(
    parameter int MAX_WINDOW = swmv_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_wr_en,
    input  logic [swmv_pkg::LEN_W-1:0]                    window_len,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic signed [swmv_pkg::SAMPLE_W-1:0]          sample,
    input  swmv_pkg::queue_stat_t                         q_stat,
    output logic                                          q_push,
    output logic [swmv_pkg::job_w(MAX_WINDOW)-1:0]        q_data
);

    localparam int IDX_W    = swmv_pkg::idx_w(MAX_WINDOW);
    localparam int CNT_W    = swmv_pkg::cnt_w(MAX_WINDOW);
    localparam int SUM_W    = swmv_pkg::sum_w(MAX_WINDOW);
    localparam int SQ_W     = swmv_pkg::sq_w(MAX_WINDOW);
    localparam int SAMPLE_W = swmv_pkg::SAMPLE_W;
    localparam int LEN_W    = swmv_pkg::LEN_W;
    localparam int PSQ_W    = 2 * SAMPLE_W - 1;
    localparam int LEN_INIT = (swmv_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                 : swmv_pkg::LEN_RESET;

    typedef enum logic [1:0] {
        F_IDLE   = 2'b01,
        F_UPDATE = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [CNT_W-1:0]           win_len_reg;
    logic [IDX_W-1:0]           write_slot_reg;
    logic [CNT_W-1:0]           held_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [SQ_W-1:0]            sq_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PSQ_W-1:0]           x_sq_reg;
    logic [IDX_W-1:0]           slot_reg;
    logic signed [SAMPLE_W-1:0] old_reg;

    logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];

    logic                       accept;
    logic [CNT_W-1:0]           len_clamped;
    logic [CNT_W+LEN_W-1:0]     len_wide;
    logic [CNT_W+IDX_W-1:0]     wslot_wide;
    logic [CNT_W+IDX_W-1:0]     slot_wide;
    logic [CNT_W-1:0]           slot_inc;
    logic [IDX_W-1:0]           slot_sel;
    logic [IDX_W-1:0]           slot_next;
    logic                       window_full;
    logic [CNT_W-1:0]           held_next;
    logic [SUM_W-1:0]           sum_next;
    logic [SQ_W-1:0]            sq_next;
    logic signed [31:0]         sample_prod;
    logic signed [31:0]         old_prod;
    logic [SUM_W-1:0]           x_ext;
    logic [SUM_W-1:0]           old_ext;
    logic [SQ_W-1:0]            x_sq_ext;
    logic [SQ_W-1:0]            old_sq_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !((state_reg == F_IDLE) && !q_stat.full);

    // Window length written out of range is pulled back to 2..MAX_WINDOW.
    assign len_wide = {{CNT_W{1'b0}}, window_len};

    always_comb
    begin
        if (window_len < LEN_W'(swmv_pkg::LEN_MIN))
        begin
            len_clamped = CNT_W'(swmv_pkg::LEN_MIN);
        end
        else if (32'(window_len) > 32'(MAX_WINDOW))
        begin
            len_clamped = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len_clamped = len_wide[CNT_W-1:0];
        end
    end

    assign wslot_wide = {{CNT_W{1'b0}}, write_slot_reg};
    assign slot_sel   = (wslot_wide[CNT_W-1:0] >= win_len_reg) ? '0 : write_slot_reg;

    assign slot_wide = {{CNT_W{1'b0}}, slot_reg};
    assign slot_inc  = slot_wide[CNT_W-1:0] + CNT_W'(1);
    assign slot_next = (slot_inc >= win_len_reg) ? '0 : slot_inc[IDX_W-1:0];

    assign sample_prod = sample * sample;
    assign old_prod    = old_reg * old_reg;

    assign x_ext      = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign old_ext    = {{(SUM_W-SAMPLE_W){old_reg[SAMPLE_W-1]}}, old_reg};
    assign x_sq_ext   = {{(SQ_W-PSQ_W){1'b0}}, x_sq_reg};
    assign old_sq_ext = {{(SQ_W-PSQ_W){1'b0}}, old_prod[PSQ_W-1:0]};

    // A full window drops its oldest sample, which sits in the slot about to be written.
    assign window_full = (held_reg >= win_len_reg);
    assign held_next   = window_full ? held_reg : held_reg + CNT_W'(1);
    assign sum_next    = sum_reg - (window_full ? old_ext : '0) + x_ext;
    assign sq_next     = sq_reg - (window_full ? old_sq_ext : '0) + x_sq_ext;

    assign q_push = (state_reg == F_UPDATE);
    assign q_data = {sum_next, sq_next, held_next};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            win_len_reg    <= CNT_W'(LEN_INIT);
            write_slot_reg <= '0;
            held_reg       <= '0;
            sum_reg        <= '0;
            sq_reg         <= '0;
        end
        else if (cfg_wr_en)
        begin
            state_reg      <= F_IDLE;
            win_len_reg    <= len_clamped;
            write_slot_reg <= '0;
            held_reg       <= '0;
            sum_reg        <= '0;
            sq_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_UPDATE)
            begin
                write_slot_reg <= slot_next;
                held_reg       <= held_next;
                sum_reg        <= sum_next;
                sq_reg         <= sq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            x_sq_reg   <= sample_prod[PSQ_W-1:0];
            slot_reg   <= slot_sel;
        end
    end

    // Sample ring: read of the oldest sample on acceptance, write of the new one in the following cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_UPDATE)
        begin
            ring[slot_reg] <= sample_reg;
        end
        if (accept)
        begin
            old_reg <= ring[slot_sel];
        end
    end

endmodule

>>> rtl/swmv_queue.sv
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module swmv_queue #(
    parameter int DATA_W = swmv_pkg::job_w(swmv_pkg::DEFAULT_MAX_WINDOW)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     pop_data,
    output swmv_pkg::queue_stat_t stat
);

    localparam int DEPTH = swmv_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/swmv_divider.sv
// Shared restoring divider retiring two quotient bits per cycle.
`timescale 1ns / 1ps

module swmv_divider #(
    parameter int MAX_WINDOW = swmv_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [swmv_pkg::dvd_w(MAX_WINDOW)-1:0] dividend,
    input  logic [swmv_pkg::den_w(MAX_WINDOW)-1:0] divisor,
    output swmv_pkg::div_stat_t                    stat,
    output logic [swmv_pkg::dvd_w(MAX_WINDOW)-1:0] quotient,
    output logic [swmv_pkg::den_w(MAX_WINDOW)-1:0] remainder
);

    localparam int DVD_W = swmv_pkg::dvd_w(MAX_WINDOW);
    localparam int DEN_W = swmv_pkg::den_w(MAX_WINDOW);
    localparam int STEP  = swmv_pkg::DIV_BITS_PER_CYCLE;
    localparam int ITER  = (DVD_W + STEP - 1) / STEP;
    localparam int PAD_W = ITER * STEP;
    localparam int IT_W  = (ITER > 1) ? $clog2(ITER) : 1;

    logic                   busy_reg;
    logic                   done_reg;
    logic [IT_W-1:0]        iter_reg;
    logic [PAD_W-1:0]       quo_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [DEN_W-1:0]       den_reg;

    logic [PAD_W-1:0]       quo_step;
    logic [DEN_W-1:0]       rem_step;
    logic [PAD_W+DVD_W-1:0] dvd_wide;
    logic                   load;

    assign load     = start && !busy_reg;
    assign dvd_wide = {{PAD_W{1'b0}}, dividend};

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[DVD_W-1:0];
    assign remainder = rem_reg;

    // Shift STEP dividend bits into the partial remainder one at a time, subtracting where each fits.
    always_comb
    begin
        logic [DEN_W:0]   trial;
        logic [PAD_W-1:0] quo_v;
        logic [DEN_W-1:0] rem_v;
        quo_v = quo_reg;
        rem_v = rem_reg;
        for (int k = 0; k < STEP; k++)
        begin
            trial = {rem_v, quo_v[PAD_W-1]};
            quo_v = {quo_v[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial    = trial - {1'b0, den_reg};
                quo_v[0] = 1'b1;
            end
            rem_v = trial[DEN_W-1:0];
        end
        quo_step = quo_v;
        rem_step = rem_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (iter_reg == IT_W'(ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                iter_reg <= iter_reg + IT_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dvd_wide[PAD_W-1:0];
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

endmodule

>>> rtl/swmv_back.sv
// Back end: turns a queued job into floored mean and sample variance and holds the result.
`timescale 1ns / 1ps

module swmv_back #(
    parameter int MAX_WINDOW = swmv_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  swmv_pkg::queue_stat_t                  q_stat,
    input  logic [swmv_pkg::job_w(MAX_WINDOW)-1:0] q_data,
    output logic                                   q_pop,
    output logic                                   div_start,
    output logic [swmv_pkg::dvd_w(MAX_WINDOW)-1:0] div_dividend,
    output logic [swmv_pkg::den_w(MAX_WINDOW)-1:0] div_divisor,
    input  swmv_pkg::div_stat_t                    div_stat,
    input  logic [swmv_pkg::dvd_w(MAX_WINDOW)-1:0] div_quotient,
    input  logic [swmv_pkg::den_w(MAX_WINDOW)-1:0] div_remainder,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [swmv_pkg::MEAN_W-1:0]     mean_q8,
    output logic [swmv_pkg::VAR_W-1:0]             variance_q8,
    output logic [swmv_pkg::HELD_W-1:0]            samples_held
);

    localparam int CNT_W  = swmv_pkg::cnt_w(MAX_WINDOW);
    localparam int SUM_W  = swmv_pkg::sum_w(MAX_WINDOW);
    localparam int SQ_W   = swmv_pkg::sq_w(MAX_WINDOW);
    localparam int NUM_W  = swmv_pkg::num_w(MAX_WINDOW);
    localparam int DVD_W  = swmv_pkg::dvd_w(MAX_WINDOW);
    localparam int DEN_W  = swmv_pkg::den_w(MAX_WINDOW);
    localparam int FRAC_W = swmv_pkg::FRAC_W;
    localparam int MEAN_W = swmv_pkg::MEAN_W;
    localparam int VAR_W  = swmv_pkg::VAR_W;
    localparam int HELD_W = swmv_pkg::HELD_W;
    localparam int PA_W   = CNT_W + SQ_W;
    localparam int PB_W   = 2 * SUM_W;
    localparam int MD_W   = SUM_W + FRAC_W;

    typedef enum logic [5:0] {
        B_IDLE     = 6'b000001,
        B_MUL      = 6'b000010,
        B_SUB      = 6'b000100,
        B_DIV_VAR  = 6'b001000,
        B_DIV_MEAN = 6'b010000,
        B_DONE     = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [PA_W-1:0]    prod_a_reg;
    logic [PB_W-1:0]    prod_b_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [VAR_W-1:0]   var_res_reg;
    logic [MEAN_W-1:0]  mean_res_reg;
    logic               out_valid_reg;
    logic [MEAN_W-1:0]  mean_out_reg;
    logic [VAR_W-1:0]   var_out_reg;
    logic [HELD_W-1:0]  held_out_reg;

    logic               sum_neg;
    logic [SUM_W-1:0]   mag;
    logic [PA_W-1:0]    prod_a_next;
    logic [PB_W-1:0]    prod_b_next;
    logic [DEN_W-1:0]   den_next;
    logic [NUM_W+PA_W-1:0] a_wide;
    logic [NUM_W+PB_W-1:0] b_wide;
    logic [NUM_W-1:0]   var_num;
    logic [DVD_W-1:0]   var_dvd;
    logic [DVD_W+MD_W-1:0] mean_wide;
    logic [DVD_W-1:0]   mean_dvd;
    logic [DEN_W-1:0]   n_ext;
    logic [MEAN_W-1:0]  q_low;
    logic [MEAN_W-1:0]  q_adj;
    logic [MEAN_W-1:0]  mean_res_next;
    logic [VAR_W-1:0]   var_res_next;
    logic [CNT_W+HELD_W-1:0] held_wide;
    logic               out_load;

    assign sum_neg = sum_reg[SUM_W-1];
    assign mag     = sum_neg ? (~sum_reg + SUM_W'(1)) : sum_reg;

    assign prod_a_next = {{SQ_W{1'b0}}, n_reg} * {{CNT_W{1'b0}}, sq_reg};
    assign prod_b_next = {{SUM_W{1'b0}}, mag} * {{SUM_W{1'b0}}, mag};
    assign den_next    = {{CNT_W{1'b0}}, n_reg} * {{CNT_W{1'b0}}, n_reg - CNT_W'(1)};

    // n*sumsq - sum^2 is never negative.
    assign a_wide  = {{NUM_W{1'b0}}, prod_a_reg};
    assign b_wide  = {{NUM_W{1'b0}}, prod_b_reg};
    assign var_num = a_wide[NUM_W-1:0] - b_wide[NUM_W-1:0];
    assign var_dvd = {var_num, {FRAC_W{1'b0}}};

    assign mean_wide = {{DVD_W{1'b0}}, mag, {FRAC_W{1'b0}}};
    assign mean_dvd  = mean_wide[DVD_W-1:0];
    assign n_ext     = {{CNT_W{1'b0}}, n_reg};

    assign div_start    = (state_reg == B_SUB) || ((state_reg == B_DIV_VAR) && div_stat.done);
    assign div_dividend = (state_reg == B_SUB) ? var_dvd : mean_dvd;
    assign div_divisor  = (state_reg == B_SUB) ? den_reg : n_ext;

    // A single sample has no spread; the divisor is zero then and the quotient is dropped.
    assign var_res_next = (n_reg < CNT_W'(2)) ? '0 : div_quotient[VAR_W-1:0];

    // Floor of a negative mean: negate the magnitude quotient, rounded up on a remainder.
    assign q_low         = div_quotient[MEAN_W-1:0];
    assign q_adj         = q_low + ((div_remainder != '0) ? MEAN_W'(1) : '0);
    assign mean_res_next = sum_neg ? (~q_adj + MEAN_W'(1)) : q_low;

    assign held_wide = {{HELD_W{1'b0}}, n_reg};

    assign q_pop    = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid    = out_valid_reg;
    assign mean_q8      = $signed(mean_out_reg);
    assign variance_q8  = var_out_reg;
    assign samples_held = held_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_SUB;
            end
            B_SUB:
            begin
                state_next = B_DIV_VAR;
            end
            B_DIV_VAR:
            begin
                if (div_stat.done)
                begin
                    state_next = B_DIV_MEAN;
                end
            end
            B_DIV_MEAN:
            begin
                if (div_stat.done)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            {sum_reg, sq_reg, n_reg} <= q_data;
        end
        if (state_reg == B_MUL)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            den_reg    <= den_next;
        end
        if ((state_reg == B_DIV_VAR) && div_stat.done)
        begin
            var_res_reg <= var_res_next;
        end
        if ((state_reg == B_DIV_MEAN) && div_stat.done)
        begin
            mean_res_reg <= mean_res_next;
        end
        if (out_load)
        begin
            mean_out_reg <= mean_res_reg;
            var_out_reg  <= var_res_reg;
            held_out_reg <= held_wide[HELD_W-1:0];
        end
    end

endmodule

>>> rtl/sliding_window_mean_variance.sv
// Top level of the sliding-window mean and sample variance block.
`timescale 1ns / 1ps

// Usage
// Each input transaction carries one signed 16-bit sample on sample, taken when in_valid is
// high and in_stall is low. Each accepted sample yields exactly one output transaction with
// the floored Q.8 mean, the floored Q.8 sample variance (divisor n-1) and the number of
// samples the figures cover, taken when out_valid is high and out_stall is low.
// Writing window_len with cfg_wr_en high restarts the window with the new length, clamped to
// 2..MAX_WINDOW; write it only while no transaction is in flight.
// The front end takes a sample and updates its sums before it takes the next, while the
// job queue has room. The back end finishes one transaction before it pops the next: both
// divisions run in turn on the one shared divider, two quotient bits a cycle.
// Reset leaves the window empty with a window length of 64 (or MAX_WINDOW if smaller).
// The sample ring needs no clearing pass, as a slot's value is used only once written.
// A stalled receiver holds the result in the output register; the back end then waits with
// its next result, and the front end keeps taking samples until the two-entry queue fills.

module sliding_window_mean_variance #(
    parameter int MAX_WINDOW = swmv_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swmv_pkg::LEN_W-1:0]          window_len,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [swmv_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [swmv_pkg::MEAN_W-1:0]  mean_q8,
    output logic [swmv_pkg::VAR_W-1:0]          variance_q8,
    output logic [swmv_pkg::HELD_W-1:0]         samples_held
);

    localparam int JOB_W = swmv_pkg::job_w(MAX_WINDOW);
    localparam int DVD_W = swmv_pkg::dvd_w(MAX_WINDOW);
    localparam int DEN_W = swmv_pkg::den_w(MAX_WINDOW);

    // Front end to queue: one job per sample with the sums after that sample.
    logic                  q_push;
    logic [JOB_W-1:0]      q_push_data;
    logic                  q_pop;
    logic [JOB_W-1:0]      q_pop_data;
    swmv_pkg::queue_stat_t q_stat;

    // Back end to the shared divider.
    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic [DVD_W-1:0]      div_quotient;
    logic [DEN_W-1:0]      div_remainder;
    swmv_pkg::div_stat_t   div_stat;

    swmv_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .window_len (window_len),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_push_data)
    );

    swmv_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    swmv_divider #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    swmv_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_stat      (div_stat),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean_q8       (mean_q8),
        .variance_q8   (variance_q8),
        .samples_held  (samples_held)
    );

    // Every accepted sample reaches the queue on the following cycle.
    a_accept_pushes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !cfg_wr_en) |=> q_push
    ) else $error("accepted sample was not queued");

    // The front end must never push into a full queue, or a transaction would be lost.
    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full
    ) else $error("job pushed into a full queue");

    // The divider is shared; a new division may only start once the previous one is over.
    a_no_start_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy
    ) else $error("division started while the divider was busy");

endmodule

>>> test/sliding_window_mean_variance_test.sv
// Self-checking testbench for the sliding-window mean and sample variance block.
`timescale 1ns / 1ps

module sliding_window_mean_variance_test;

    localparam int SAMPLE_W      = swmv_pkg::SAMPLE_W;
    localparam int MEAN_W        = swmv_pkg::MEAN_W;
    localparam int VAR_W         = swmv_pkg::VAR_W;
    localparam int HELD_W        = swmv_pkg::HELD_W;
    localparam int LEN_W         = swmv_pkg::LEN_W;
    localparam int LEN_RESET     = swmv_pkg::LEN_RESET;
    localparam int LEN_MIN       = swmv_pkg::LEN_MIN;

    // The ring in the predictor matches the default build of the block.
    localparam int RING_DEPTH    = swmv_pkg::DEFAULT_MAX_WINDOW;
    // The slowest correct run is roughly 900 transactions plus one long hold-off and the
    // drains between phases; the limit is many times that.
    localparam int CYCLE_LIMIT   = 600000;
    // Long enough to cover one full pass from acceptance to out_valid.
    localparam int DRAIN_CYCLES  = 80;
    // Long enough for the two-entry job queue and the output register to fill up.
    localparam int HOLD_CYCLES   = 400;
    localparam int SEGMENT_ITEMS = 142;
    localparam int SEGMENTS      = 6;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic [HELD_W-1:0]        held;
    } window_stats_t;

    // Every input of the block has a known value from time zero.
    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]            window_len  = LEN_W'(LEN_RESET);
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample      = '0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic signed [MEAN_W-1:0]    mean_q8;
    logic [VAR_W-1:0]            variance_q8;
    logic [HELD_W-1:0]           samples_held;

    // Set by the stimulus process to force a long receiver hold-off.
    logic                        hold_off    = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic signed [SAMPLE_W-1:0] sample_backlog [$];
    window_stats_t              stats_due [$];

    int mismatch_count  = 0;
    int samples_taken   = 0;
    int results_checked = 0;
    int settings_tried  = 0;

    // Predictor state: its own copy of the window and of the length register.
    logic signed [SAMPLE_W-1:0] window_ring [RING_DEPTH];
    int                         next_slot   = 0;
    int                         fill_count  = 0;
    int                         active_len  = LEN_RESET;
    longint                     total_sum   = 0;
    longint                     total_sqsum = 0;

    sliding_window_mean_variance dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .window_len   (window_len),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_q8      (mean_q8),
        .variance_q8  (variance_q8),
        .samples_held (samples_held)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Adds one sample to the predicted window and queues the statistics it produces.
    // When the window is full the oldest sample, held in the slot about to be written,
    // leaves both sums first.
    task advance_window(input logic signed [SAMPLE_W-1:0] x);
        int            slot;
        longint        xv;
        longint        oldest;
        longint        n;
        longint        scaled;
        longint        quot;
        longint        spread;
        longint        var_l;
        window_stats_t st;
        slot = next_slot;
        if (slot >= active_len)
        begin
            slot = 0;
        end
        xv = x;
        if (fill_count >= active_len)
        begin
            oldest = window_ring[slot];
            total_sum -= oldest;
            total_sqsum -= oldest * oldest;
        end
        else
        begin
            fill_count++;
        end
        window_ring[slot] = x;
        total_sum += xv;
        total_sqsum += xv * xv;
        slot++;
        if (slot >= active_len)
        begin
            slot = 0;
        end
        next_slot = slot;

        n = fill_count;
        // Floor toward minus infinity, not toward zero.
        scaled = total_sum * 256;
        quot = scaled / n;
        if ((scaled % n) != 0 && scaled < 0)
        begin
            quot--;
        end
        // A single sample has no spread to speak of.
        if (fill_count < 2)
        begin
            var_l = 0;
        end
        else
        begin
            spread = n * total_sqsum - total_sum * total_sum;
            var_l = (spread * 256) / (n * (n - 1));
        end
        st.mean = quot[MEAN_W-1:0];
        st.variance = var_l[VAR_W-1:0];
        st.held = HELD_W'(fill_count);
        stats_due.push_back(st);
    endtask

    // Writes the length register while the block is idle. The block clamps the value to
    // 2..64 and empties its window, and so does the predictor.
    task apply_window_len(input logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        window_len <= v;
        if (v < LEN_MIN)
        begin
            active_len = LEN_MIN;
        end
        else if (v > RING_DEPTH)
        begin
            active_len = RING_DEPTH;
        end
        else
        begin
            active_len = v;
        end
        next_slot = 0;
        fill_count = 0;
        total_sum = 0;
        total_sqsum = 0;
        settings_tried++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Polls on the falling edge so that the view of the queues is settled.
    task wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (sample_backlog.size() != 0 || in_valid || stats_due.size() != 0);
    endtask

    // A mix of extremes, values near zero, repeats and uniform full-range samples.
    function logic signed [SAMPLE_W-1:0] pick_sample(input logic signed [SAMPLE_W-1:0] prev);
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0: pick_sample = r[0] ? 16'sh7FFF : 16'sh8000;
            1: pick_sample = SAMPLE_W'($signed($urandom_range(16)) - 8);
            2: pick_sample = prev;
            default: pick_sample = r[SAMPLE_W-1:0];
        endcase
    endfunction

    task queue_random_samples(input int count);
        logic signed [SAMPLE_W-1:0] x;
        x = '0;
        @(negedge clk);
        repeat (count)
        begin
            x = pick_sample(x);
            sample_backlog.push_back(x);
        end
    endtask

    // Driver: the payload and valid only move when the current transaction has gone or no
    // transaction is on offer, so a stalled sample stays put.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_window(sample);
                samples_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    sample <= sample_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task check_result();
        window_stats_t want;
        if (stats_due.size() == 0)
        begin
            report_mismatch("result transaction arrived with no sample outstanding");
        end
        else
        begin
            want = stats_due.pop_front();
            results_checked++;
            if (mean_q8 !== want.mean)
            begin
                report_mismatch($sformatf("mean_q8 %0d, predicted %0d", mean_q8, want.mean));
            end
            if (variance_q8 !== want.variance)
            begin
                report_mismatch($sformatf("variance_q8 %0d, predicted %0d",
                                          variance_q8, want.variance));
            end
            if (samples_held !== want.held)
            begin
                report_mismatch($sformatf("samples_held %0d, predicted %0d",
                                          samples_held, want.held));
            end
        end
    endtask

    // Monitor: takes each result transaction and stalls at random, or solidly while the
    // long hold-off is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (hold_off)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        int cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++)
        begin
            @(posedge clk);
        end
        $display("Run stopped by the cycle limit with %0d results outstanding.",
                 stats_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int               seg;
        logic [LEN_W-1:0] seg_len;

        // Reset is held once, at the start.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with no idling. A written length of zero is taken as two, so the
        // window is full from the second sample on and opposite extremes pass through it.
        apply_window_len(7'd0);
        @(negedge clk);
        sample_backlog.push_back(16'sh7FFF);
        sample_backlog.push_back(16'sh8000);
        sample_backlog.push_back(16'sh8000);
        sample_backlog.push_back(16'sh7FFF);
        sample_backlog.push_back(-16'sd1);
        sample_backlog.push_back(16'sd0);
        wait_drained();

        // A short window swinging from one extreme to the other, the widest spread there is.
        apply_window_len(7'd3);
        @(negedge clk);
        repeat (3) sample_backlog.push_back(16'sh8000);
        repeat (3) sample_backlog.push_back(16'sh7FFF);
        wait_drained();

        // A length above the ring size is taken as the full ring.
        apply_window_len(7'd127);
        @(negedge clk);
        sample_backlog.push_back(16'sh7FFF);
        sample_backlog.push_back(16'sh8000);
        sample_backlog.push_back(16'sd0);
        sample_backlog.push_back(16'sh5555);
        sample_backlog.push_back(16'shAAAA);
        wait_drained();

        // Random part in six segments, each longer than the widest window so that every
        // window wraps. The first two idle mostly at the receiver, the next two mostly at
        // the sender, and the last two run back to back.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: seg_len = 7'd2;
                1: seg_len = 7'd127;
                2: seg_len = LEN_W'($urandom_range(RING_DEPTH, LEN_MIN));
                3: seg_len = 7'd1;
                4: seg_len = LEN_W'($urandom_range(127));
                default: seg_len = 7'd64;
            endcase
            @(negedge clk);
            if (seg < 2)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 46;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_window_len(seg_len);
            queue_random_samples(SEGMENT_ITEMS);
            if (seg == 1)
            begin
                // The receiver holds off while samples keep coming, so the job queue fills
                // and the block has to stall its input.
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (stats_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted results never arrived", stats_due.size()));
        end

        $display("Checked %0d results against %0d accepted samples over %0d length settings.",
                 results_checked, samples_taken, settings_tried);
        $display("Traffic covered sender and receiver idling, back-to-back runs and one long "
                 , "output hold-off.");
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
